// ----- rtl/square_matrix_multiply_assert.svh -----
// Assertion macros shared by the square matrix multiplier RTL.
// Depends on nothing; included by the top level only.
`ifndef SQUARE_MATRIX_MULTIPLY_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smm_pkg.sv -----
// Shared types, constants and the control program of the matrix multiplier.
// No dependencies; used by the top level, the sequencer and the MAC unit.
`default_nettype none

package smm_pkg;

    // Fixed field widths
    localparam int MAX_N_DEFAULT = 8;
    localparam int SIZE_W        = 4;
    localparam int ELEM_W        = 32;
    localparam int PROD_W        = 64;
    localparam int ROW_W         = 3;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Program step numbers
    typedef logic [2:0] step_t;
    localparam step_t STEP_LOAD  = 3'd0;
    localparam step_t STEP_START = 3'd1;
    localparam step_t STEP_MAC   = 3'd2;
    localparam step_t STEP_DRAIN = 3'd3;
    localparam step_t STEP_OUT   = 3'd4;
    localparam step_t STEP_NEXT  = 3'd5;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS     = 3'd0,
        COND_LOAD_DONE  = 3'd1,
        COND_K_LAST     = 3'd2,
        COND_PIPE_EMPTY = 3'd3,
        COND_OUT_FREE   = 3'd4,
        COND_RC_LAST    = 3'd5
    } cond_t;

    // One control word
    typedef struct packed {
        logic  in_ready;
        logic  issue;
        logic  acc_clr;
        logic  rc_clr;
        logic  rc_adv;
        logic  out_load;
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } uword_t;

    // Status seen by the sequencer
    typedef struct packed {
        logic load_done;
        logic k_last;
        logic pipe_empty;
        logic out_free;
        logic rc_last;
    } flags_t;

    // Control program in read-only form
    function automatic uword_t microcode(input step_t step);
        uword_t w;
        w = '0;
        w.cond      = COND_ALWAYS;
        w.tgt_true  = STEP_LOAD;
        w.tgt_false = STEP_LOAD;
        case (step)
            STEP_LOAD:
            begin
                w.in_ready  = 1'b1;
                w.cond      = COND_LOAD_DONE;
                w.tgt_true  = STEP_START;
                w.tgt_false = STEP_LOAD;
            end
            STEP_START:
            begin
                w.acc_clr   = 1'b1;
                w.rc_clr    = 1'b1;
                w.tgt_true  = STEP_MAC;
            end
            STEP_MAC:
            begin
                w.issue     = 1'b1;
                w.cond      = COND_K_LAST;
                w.tgt_true  = STEP_DRAIN;
                w.tgt_false = STEP_MAC;
            end
            STEP_DRAIN:
            begin
                w.cond      = COND_PIPE_EMPTY;
                w.tgt_true  = STEP_OUT;
                w.tgt_false = STEP_DRAIN;
            end
            STEP_OUT:
            begin
                w.out_load  = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.tgt_true  = STEP_NEXT;
                w.tgt_false = STEP_OUT;
            end
            STEP_NEXT:
            begin
                w.acc_clr   = 1'b1;
                w.rc_adv    = 1'b1;
                w.cond      = COND_RC_LAST;
                w.tgt_true  = STEP_LOAD;
                w.tgt_false = STEP_MAC;
            end
            default:
            begin
                w.tgt_true  = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/square_matrix_multiply.sv -----
// Top level of the square matrix multiplier: load counter, loop counters,
// output register. Depends on smm_pkg, smm_store, smm_sequencer, smm_mac.
//
//  channel  signals                                         direction
//  cfg      cfg_valid / cfg_ready, matrix_size              in
//  in       in_valid / in_ready, element                    in
//  out      out_valid / out_ready, product, row_index,
//           column_index, saturated, last_result            out
//
// Loading takes 2*n*n element beats per matrix pair. Each C element is then
// computed on the single multiply-accumulate unit, one read per store per
// cycle. Reset needs no clearing pass; stores are not cleared.
// A stalled output holds the sequencer at its output step; the output
// register lets the next load start while the last result waits.
`default_nettype none
`include "square_matrix_multiply_assert.svh"

module square_matrix_multiply #(
    parameter int MAX_N = smm_pkg::MAX_N_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic        [smm_pkg::SIZE_W-1:0]  matrix_size,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [smm_pkg::ELEM_W-1:0]  element,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed      [smm_pkg::PROD_W-1:0]  product,
    output logic             [smm_pkg::ROW_W-1:0]   row_index,
    output logic             [smm_pkg::ROW_W-1:0]   column_index,
    output logic                                    saturated,
    output logic                                    last_result
);

    localparam int SIZE_W = smm_pkg::SIZE_W;
    localparam int ELEM_W = smm_pkg::ELEM_W;
    localparam int PROD_W = smm_pkg::PROD_W;
    localparam int ROW_W  = smm_pkg::ROW_W;
    localparam int N_W    = $clog2(MAX_N + 1);
    localparam int IDX_W  = $clog2(MAX_N);
    localparam int ADDR_W = $clog2(MAX_N * MAX_N);
    localparam int LC_W   = $clog2(2 * MAX_N * MAX_N + 1);

    // Configuration and load state
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic [LC_W-1:0]   lc_reg;
    logic [LC_W-1:0]   lc_next;
    logic [N_W-1:0]    n_use;
    logic [N_W-1:0]    n_last;
    logic [LC_W-1:0]   nn;
    logic [LC_W-1:0]   two_nn;
    logic [LC_W-1:0]   lc_inc;
    logic [LC_W-1:0]   b_off;
    logic              cfg_fire;
    logic              in_fire;
    logic              in_a_phase;
    logic              load_last;

    // Loop counters
    logic [IDX_W-1:0]  r_reg;
    logic [IDX_W-1:0]  r_next;
    logic [IDX_W-1:0]  c_reg;
    logic [IDX_W-1:0]  c_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  k_next;
    logic              c_last;
    logic              r_last;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;

    // Sequencer and datapath links
    smm_pkg::flags_t   flags;
    smm_pkg::uword_t   ctrl;
    smm_pkg::step_t    step;
    logic [ELEM_W-1:0] a_rd;
    logic [ELEM_W-1:0] b_rd;
    logic              mac_busy;
    logic [PROD_W-1:0] mac_result;
    logic              mac_sat;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              out_load;
    logic [PROD_W-1:0] product_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic              sat_reg;
    logic              last_reg;

    // Size in use, clamped to the supported range
    always_comb
    begin
        if (size_reg < SIZE_W'(2))
        begin
            n_use = N_W'(2);
        end
        else if (size_reg > SIZE_W'(MAX_N))
        begin
            n_use = N_W'(MAX_N);
        end
        else
        begin
            n_use = N_W'(size_reg);
        end
        n_last = n_use - N_W'(1);
        nn     = LC_W'(n_use) * LC_W'(n_use);
        two_nn = nn << 1;
    end

    // Load bookkeeping
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign in_ready   = ctrl.in_ready;
    assign in_fire    = in_valid && in_ready;
    assign in_a_phase = lc_reg < nn;
    assign lc_inc     = lc_reg + LC_W'(1);
    assign b_off      = lc_reg - nn;
    assign load_last  = lc_inc == two_nn;

    always_comb
    begin
        size_next = size_reg;
        lc_next   = lc_reg;
        if (cfg_fire)
        begin
            size_next = matrix_size;
            lc_next   = '0;
        end
        else if (in_fire)
        begin
            lc_next = load_last ? '0 : lc_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= smm_pkg::SIZE_RESET;
            lc_reg   <= '0;
        end
        else
        begin
            size_reg <= size_next;
            lc_reg   <= lc_next;
        end
    end

    // Loop counters and read addresses
    assign c_last  = N_W'(c_reg) == n_last;
    assign r_last  = N_W'(r_reg) == n_last;
    assign a_raddr = ADDR_W'(ADDR_W'(r_reg) * ADDR_W'(n_use) + ADDR_W'(k_reg));
    assign b_raddr = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(n_use) + ADDR_W'(c_reg));

    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        k_next = k_reg;
        if (ctrl.issue)
        begin
            k_next = k_reg + IDX_W'(1);
        end
        if (ctrl.acc_clr)
        begin
            k_next = '0;
        end
        if (ctrl.rc_clr)
        begin
            r_next = '0;
            c_next = '0;
        end
        else if (ctrl.rc_adv)
        begin
            if (c_last)
            begin
                c_next = '0;
                r_next = r_reg + IDX_W'(1);
            end
            else
            begin
                c_next = c_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
            c_reg <= c_next;
            k_reg <= k_next;
        end
    end

    // Matrix stores
    smm_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_a_store (
        .clk     (clk),
        .wr_en   (in_fire && in_a_phase),
        .wr_addr (lc_reg[ADDR_W-1:0]),
        .wr_data (element),
        .rd_en   (ctrl.issue),
        .rd_addr (a_raddr),
        .rd_data (a_rd)
    );

    smm_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_b_store (
        .clk     (clk),
        .wr_en   (in_fire && !in_a_phase),
        .wr_addr (b_off[ADDR_W-1:0]),
        .wr_data (element),
        .rd_en   (ctrl.issue),
        .rd_addr (b_raddr),
        .rd_data (b_rd)
    );

    // Multiply-accumulate unit
    smm_mac #(
        .MAX_N (MAX_N)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (ctrl.issue),
        .acc_clr (ctrl.acc_clr),
        .a_data  (a_rd),
        .b_data  (b_rd),
        .busy    (mac_busy),
        .result  (mac_result),
        .sat     (mac_sat)
    );

    // Status for the sequencer
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        flags.load_done  = in_fire && load_last;
        flags.k_last     = N_W'(k_reg) == n_last;
        flags.pipe_empty = !mac_busy;
        flags.out_free   = out_free;
        flags.rc_last    = r_last && c_last;
    end

    smm_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .step  (step)
    );

    // Output register: load a finished element, drop it once taken
    assign out_load = ctrl.out_load && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            product_reg <= mac_result;
            row_reg     <= r_reg;
            col_reg     <= c_reg;
            sat_reg     <= mac_sat;
            last_reg    <= r_last && c_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign product      = product_reg;
    assign row_index    = ROW_W'(row_reg);
    assign column_index = ROW_W'(col_reg);
    assign saturated    = sat_reg;
    assign last_result  = last_reg;

    // Loading only with the pipeline empty
    `SMM_ASSERT_SAME(a_load_idle, clk, rst_n, in_ready, !mac_busy, "element taken while MAC busy")
    // Reads stay inside the loaded matrices
    `SMM_ASSERT_SAME(a_read_range, clk, rst_n, ctrl.issue,
        (LC_W'(a_raddr) < nn) && (LC_W'(b_raddr) < nn), "store read outside matrix")
    // Load count never passes the end of a load
    `SMM_ASSERT_SAME(a_lc_range, clk, rst_n, 1'b1, lc_reg < two_nn, "load count out of range")
    // The last result of a pair sends the sequencer back toward loading
    `SMM_ASSERT_NEXT(a_last_wrap, clk, rst_n, out_load && r_last && c_last,
        step == smm_pkg::STEP_NEXT, "last result not followed by wrap step")

endmodule

`default_nettype wire

// ----- rtl/smm_store.sv -----
// One matrix store: single write port, single registered read port.
// No dependencies; instantiated twice by the top level.
`default_nettype none

module smm_store #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write incoming element
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/smm_sequencer.sv -----
// Step counter and control-word lookup of the matrix multiplier.
// Depends on smm_pkg for the program, control word and status types.
`default_nettype none

module smm_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire smm_pkg::flags_t flags,
    output smm_pkg::uword_t      ctrl,
    output smm_pkg::step_t       step
);

    smm_pkg::step_t  pc_reg;
    smm_pkg::step_t  pc_next;
    smm_pkg::uword_t uw;
    logic            cond_true;

    // Fetch the current control word
    always_comb
    begin
        uw = smm_pkg::microcode(pc_reg);
    end

    // Evaluate the jump condition
    always_comb
    begin
        case (uw.cond)
            smm_pkg::COND_ALWAYS:     cond_true = 1'b1;
            smm_pkg::COND_LOAD_DONE:  cond_true = flags.load_done;
            smm_pkg::COND_K_LAST:     cond_true = flags.k_last;
            smm_pkg::COND_PIPE_EMPTY: cond_true = flags.pipe_empty;
            smm_pkg::COND_OUT_FREE:   cond_true = flags.out_free;
            smm_pkg::COND_RC_LAST:    cond_true = flags.rc_last;
            default:                  cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uw.tgt_true : uw.tgt_false;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= smm_pkg::STEP_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = uw;
    assign step = pc_reg;

endmodule

`default_nettype wire

// ----- rtl/smm_mac.sv -----
// Multiply-accumulate pipeline with 64-bit saturation of the dot product.
// Depends on smm_pkg for element and product widths.
`default_nettype none

module smm_mac #(
    parameter int MAX_N = smm_pkg::MAX_N_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              issue,
    input  wire logic                              acc_clr,
    input  wire logic signed [smm_pkg::ELEM_W-1:0] a_data,
    input  wire logic signed [smm_pkg::ELEM_W-1:0] b_data,
    output logic                                   busy,
    output logic signed      [smm_pkg::PROD_W-1:0] result,
    output logic                                   sat
);

    localparam int PROD_W = smm_pkg::PROD_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_N) + 1;

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [ACC_W-PROD_W:0]    top_bits;

    // Track read data and product validity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    // Multiply the store read data
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= a_data * b_data;
        end
    end

    // Accumulate products exactly
    always_comb
    begin
        acc_next = acc_reg;
        if (acc_clr)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Clip to signed 64 bits
    assign top_bits = acc_reg[ACC_W-1:PROD_W-1];
    assign sat      = !((&top_bits) || !(|top_bits));
    assign busy     = v1_reg || v2_reg;

    always_comb
    begin
        if (!sat)
        begin
            result = acc_reg[PROD_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            result = {1'b1, {(PROD_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(PROD_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire
